// ===== rtl/core/gnms_pkg.sv =====
// shared constants, state codes and control structs for the nms block
`default_nettype none

package gnms_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int MAX_BOXES_DEF  = 256;

   localparam int THR_BITS   = 16;
   localparam int INDEX_BITS = 8;
   localparam int SEEN_BITS  = 9;

   localparam logic [THR_BITS-1:0]   THR_RESET = 16'd29491;
   localparam logic [INDEX_BITS-1:0] INDEX_SAT = 8'd255;
   localparam logic [SEEN_BITS-1:0]  SEEN_SAT  = 9'd511;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AREA,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } gnms_state_type;

   typedef struct packed {
      logic start;
      logic issue;
   } gnms_scan_ctl_type;

   typedef struct packed {
      logic busy;
      logic hit;
   } gnms_scan_sts_type;

endpackage

`default_nettype wire

// ===== rtl/core/gnms_req_if.sv =====
// request channel: one box per transfer
`default_nettype none

interface gnms_req_if #(
   parameter int COORD_BITS = gnms_pkg::COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] x_min;
   logic signed [COORD_BITS-1:0] y_min;
   logic signed [COORD_BITS-1:0] x_max;
   logic signed [COORD_BITS-1:0] y_max;
   logic                         last_in_set;

   modport source (output valid, x_min, y_min, x_max, y_max, last_in_set, input ready);
   modport sink   (input valid, x_min, y_min, x_max, y_max, last_in_set, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/gnms_rsp_if.sv =====
// response channel: one verdict per box
`default_nettype none

interface gnms_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [gnms_pkg::INDEX_BITS-1:0]     box_index;
   logic                                keep;
   logic                                overflow;
   logic                                set_done;

   modport source (output valid, box_index, keep, overflow, set_done, input ready);
   modport sink   (input valid, box_index, keep, overflow, set_done, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/greedy_nms_sorted_boxes_top.sv =====
// greedy nms over score-sorted boxes with a kept-box memory
//
//   port       dir    handshake     content
//   req_chan   in     valid/ready   x_min y_min x_max y_max last_in_set
//   rsp_chan   out    valid/ready   box_index keep overflow set_done
//   csr_*      in     write enable  iou_threshold
//
// one box at a time; each request scans every kept box of the set, paced by the single
// read port of the kept-box memory (one stored box per cycle)
// a request is taken while the previous response still waits in the output register
// a held response stalls completion of the next box only in its done state
// synchronous reset empties the set; memory contents are never cleared
`default_nettype none

module greedy_nms_sorted_boxes_top #(
   parameter int MAX_BOXES  = gnms_pkg::MAX_BOXES_DEF,
   parameter int COORD_BITS = gnms_pkg::COORD_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   gnms_req_if.sink                             req_chan,
   gnms_rsp_if.source                           rsp_chan,
   input  wire logic                            csr_wr_en,
   input  wire logic [gnms_pkg::THR_BITS-1:0]   csr_wr_data
);
   localparam int C       = COORD_BITS;
   localparam int DW      = C + 1;
   localparam int AREA_W  = 2 * C + 1;
   localparam int ENTRY_W = 4 * C + AREA_W;
   localparam int AW      = $clog2(MAX_BOXES);
   localparam int KW      = $clog2(MAX_BOXES + 1);
   localparam int SW      = gnms_pkg::SEEN_BITS;

   gnms_pkg::gnms_state_type state_ff, state_in;

   logic [gnms_pkg::THR_BITS-1:0] thr_ff;
   logic [KW-1:0] kept_ff, kept_in, scan_ff, scan_in;
   logic [SW-1:0] seen_ff, seen_in;

   // current box
   logic signed [C-1:0]      x0_ff, y0_ff, x1_ff, y1_ff;
   logic signed [DW-1:0]     dx_ff, dy_ff;
   logic signed [2*DW-1:0]   area_full;
   logic signed [AREA_W-1:0] area_ff;
   logic                     last_ff;
   logic [ENTRY_W-1:0]       cur_entry;

   // kept-box memory
   logic [ENTRY_W-1:0] kept_mem [MAX_BOXES];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               mem_we, store_ok, full;

   logic req_accept, done_fire;

   gnms_pkg::gnms_scan_ctl_type scan_ctl;
   gnms_pkg::gnms_scan_sts_type scan_sts;

   // response register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [gnms_pkg::INDEX_BITS-1:0]   idx_ff;
   logic                              keep_ff, ovf_ff, done_ff;

   assign req_accept = req_chan.valid && req_chan.ready;
   assign full       = (kept_ff == KW'(MAX_BOXES));
   assign store_ok   = !scan_sts.hit && !full;
   assign cur_entry  = {area_ff, y1_ff, x1_ff, y0_ff, x0_ff};
   assign area_full  = dx_ff * dy_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gnms_pkg::ST_IDLE: begin
            if (req_accept) state_in = gnms_pkg::ST_AREA;
         end
         gnms_pkg::ST_AREA: begin
            state_in = gnms_pkg::ST_SCAN;
         end
         gnms_pkg::ST_SCAN: begin
            if (scan_ff >= kept_ff) state_in = gnms_pkg::ST_DRAIN;
         end
         gnms_pkg::ST_DRAIN: begin
            if (!scan_sts.busy) state_in = gnms_pkg::ST_DONE;
         end
         gnms_pkg::ST_DONE: begin
            if (done_fire) state_in = gnms_pkg::ST_IDLE;
         end
         default: begin
            state_in = gnms_pkg::ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_chan.ready = 1'b0;
      scan_ctl.start = 1'b0;
      scan_ctl.issue = 1'b0;
      done_fire      = 1'b0;
      unique case (state_ff)
         gnms_pkg::ST_IDLE:  req_chan.ready = 1'b1;
         gnms_pkg::ST_AREA:  scan_ctl.start = 1'b1;
         gnms_pkg::ST_SCAN:  scan_ctl.issue = (scan_ff < kept_ff);
         gnms_pkg::ST_DRAIN: ;
         gnms_pkg::ST_DONE:  done_fire = !rsp_valid_ff || rsp_chan.ready;
         default: ;
      endcase
   end

   assign mem_we = done_fire && store_ok;

   // counters
   always_comb begin
      scan_in = scan_ff;
      kept_in = kept_ff;
      seen_in = seen_ff;
      if (scan_ctl.start) begin
         scan_in = '0;
      end else if (scan_ctl.issue) begin
         scan_in = scan_ff + KW'(1);
      end
      if (done_fire) begin
         if (last_ff) begin
            kept_in = '0;
            seen_in = '0;
         end else begin
            if (store_ok) kept_in = kept_ff + KW'(1);
            if (seen_ff != gnms_pkg::SEEN_SAT) seen_in = seen_ff + SW'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (done_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gnms_pkg::ST_IDLE;
         thr_ff       <= gnms_pkg::THR_RESET;
         kept_ff      <= '0;
         seen_ff      <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kept_ff      <= kept_in;
         seen_ff      <= seen_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) thr_ff <= csr_wr_data;
      end
   end

   // box payload and area
   always_ff @(posedge clock) begin
      if (req_accept) begin
         x0_ff   <= req_chan.x_min;
         y0_ff   <= req_chan.y_min;
         x1_ff   <= req_chan.x_max;
         y1_ff   <= req_chan.y_max;
         last_ff <= req_chan.last_in_set;
         dx_ff   <= DW'(req_chan.x_max) - DW'(req_chan.x_min);
         dy_ff   <= DW'(req_chan.y_max) - DW'(req_chan.y_min);
      end
      if (state_ff == gnms_pkg::ST_AREA) begin
         area_ff <= area_full[AREA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) kept_mem[kept_ff[AW-1:0]] <= cur_entry;
      if (scan_ctl.issue) rd_data_ff <= kept_mem[scan_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (done_fire) begin
         idx_ff  <= (seen_ff > SW'(gnms_pkg::INDEX_SAT)) ? gnms_pkg::INDEX_SAT
                                                          : seen_ff[gnms_pkg::INDEX_BITS-1:0];
         keep_ff <= store_ok;
         ovf_ff  <= !scan_sts.hit && full;
         done_ff <= last_ff;
      end
   end

   gnms_iou #(
      .COORD_BITS (COORD_BITS)
   ) u_iou (
      .clock      (clock),
      .reset      (reset),
      .ctl        (scan_ctl),
      .cur_entry  (cur_entry),
      .kept_entry (rd_data_ff),
      .thr        (thr_ff),
      .sts        (scan_sts)
   );

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.box_index = idx_ff;
   assign rsp_chan.keep      = keep_ff;
   assign rsp_chan.overflow  = ovf_ff;
   assign rsp_chan.set_done  = done_ff;

endmodule

`default_nettype wire

// ===== rtl/core/gnms_iou.sv =====
// pipelined overlap test of the current box against one stored box per cycle
`default_nettype none

module gnms_iou #(
   parameter int COORD_BITS = gnms_pkg::COORD_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire gnms_pkg::gnms_scan_ctl_type          ctl,
   input  wire logic [4*COORD_BITS+2*COORD_BITS:0]   cur_entry,
   input  wire logic [4*COORD_BITS+2*COORD_BITS:0]   kept_entry,
   input  wire logic [gnms_pkg::THR_BITS-1:0]        thr,
   output gnms_pkg::gnms_scan_sts_type               sts
);
   localparam int C       = COORD_BITS;
   localparam int DW      = C + 1;
   localparam int AREA_W  = 2 * C + 1;
   localparam int IW      = 2 * DW;
   localparam int UW      = 2 * C + 3;
   localparam int TW      = gnms_pkg::THR_BITS;
   localparam int PW      = UW + TW + 1;

   // unpacked fields, entry layout is {area, y_max, x_max, y_min, x_min}
   logic signed [C-1:0]      cx0, cy0, cx1, cy1;
   logic signed [C-1:0]      kx0, ky0, kx1, ky1;
   logic signed [AREA_W-1:0] c_area, k_area;

   assign cx0    = signed'(cur_entry[C-1:0]);
   assign cy0    = signed'(cur_entry[2*C-1:C]);
   assign cx1    = signed'(cur_entry[3*C-1:2*C]);
   assign cy1    = signed'(cur_entry[4*C-1:3*C]);
   assign c_area = signed'(cur_entry[4*C+AREA_W-1:4*C]);
   assign kx0    = signed'(kept_entry[C-1:0]);
   assign ky0    = signed'(kept_entry[2*C-1:C]);
   assign kx1    = signed'(kept_entry[3*C-1:2*C]);
   assign ky1    = signed'(kept_entry[4*C-1:3*C]);
   assign k_area = signed'(kept_entry[4*C+AREA_W-1:4*C]);

   logic v0_ff, v1_ff, v2_ff, v3_ff, v4_ff, hit_ff;
   logic v0_in, v1_in, v2_in, v3_in, v4_in, hit_in;

   // stage 1: clipped extents and disjoint test
   logic signed [C-1:0]      hi_x, lo_x, hi_y, lo_y;
   logic signed [DW-1:0]     wx_in, wy_in, wx_ff, wy_ff;
   logic                     disj_in, disj_ff;
   logic signed [AREA_W-1:0] ka1_ff, ka2_ff;

   always_comb begin
      hi_x    = (cx1 < kx1) ? cx1 : kx1;
      lo_x    = (cx0 > kx0) ? cx0 : kx0;
      hi_y    = (cy1 < ky1) ? cy1 : ky1;
      lo_y    = (cy0 > ky0) ? cy0 : ky0;
      wx_in   = DW'(hi_x) - DW'(lo_x);
      wy_in   = DW'(hi_y) - DW'(lo_y);
      disj_in = (cx0 > kx1) || (cx1 < kx0) || (cy0 > ky1) || (cy1 < ky0);
   end

   // stage 2: intersection product
   logic signed [IW-1:0] inter_full, inter_in, inter_ff, inter3_ff;

   assign inter_full = wx_ff * wy_ff;
   assign inter_in   = disj_ff ? '0 : inter_full;

   // stage 3: union
   logic signed [UW-1:0] uni_in, uni_ff;

   assign uni_in = UW'(c_area) + UW'(ka2_ff) - UW'(inter_ff);

   // stage 4: cross-multiplied ratio
   logic signed [TW:0]   thr_s;
   logic signed [PW-1:0] prod_in, prod_ff, lhs_in, lhs_ff;
   logic                 pos_in, pos_ff;

   assign thr_s   = signed'({1'b0, thr});
   assign prod_in = uni_ff * thr_s;
   assign lhs_in  = PW'(inter3_ff) <<< TW;
   assign pos_in  = !uni_ff[UW-1] && (uni_ff != '0);

   // stage 5: sticky suppression flag
   always_comb begin
      v0_in = ctl.issue;
      v1_in = v0_ff;
      v2_in = v1_ff;
      v3_in = v2_ff;
      v4_in = v3_ff;
      priority if (ctl.start) begin
         hit_in = 1'b0;
      end else if (v4_ff && pos_ff && (lhs_ff > prod_ff)) begin
         hit_in = 1'b1;
      end else begin
         hit_in = hit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff  <= 1'b0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         hit_ff <= 1'b0;
      end else begin
         v0_ff  <= v0_in;
         v1_ff  <= v1_in;
         v2_ff  <= v2_in;
         v3_ff  <= v3_in;
         v4_ff  <= v4_in;
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      wx_ff     <= wx_in;
      wy_ff     <= wy_in;
      disj_ff   <= disj_in;
      ka1_ff    <= k_area;
      inter_ff  <= inter_in;
      ka2_ff    <= ka1_ff;
      uni_ff    <= uni_in;
      inter3_ff <= inter_ff;
      prod_ff   <= prod_in;
      lhs_ff    <= lhs_in;
      pos_ff    <= pos_in;
   end

   assign sts.busy = v0_ff || v1_ff || v2_ff || v3_ff || v4_ff;
   assign sts.hit  = hit_ff;

endmodule

`default_nettype wire

// ===== rtl/core/gnms_check.sv =====
// port-level checks for the nms block, bound to the top level
`default_nettype none

module gnms_check (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_ready,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [gnms_pkg::INDEX_BITS-1:0]   box_index,
   input wire logic                              keep,
   input wire logic                              overflow,
   input wire logic                              set_done
);
   localparam int SW = gnms_pkg::SEEN_BITS;

   // expected position of the next response within its set
   logic [SW-1:0]                   pos_ff, pos_in;
   logic [gnms_pkg::INDEX_BITS-1:0] pos_sat;

   always_comb begin
      pos_in = pos_ff;
      if (rsp_valid && rsp_ready) begin
         if (set_done) begin
            pos_in = '0;
         end else if (pos_ff != gnms_pkg::SEEN_SAT) begin
            pos_in = pos_ff + SW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   assign pos_sat = (pos_ff > SW'(gnms_pkg::INDEX_SAT)) ? gnms_pkg::INDEX_SAT
                                                         : pos_ff[gnms_pkg::INDEX_BITS-1:0];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(box_index) && $stable(keep))
      else $error("response changed while stalled");

   a_keep_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(keep && overflow))
      else $error("box both kept and overflowed");

   a_one_box: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while a box is in work");

   a_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> box_index == pos_sat)
      else $error("box index out of sequence");

endmodule

bind greedy_nms_sorted_boxes_top gnms_check u_gnms_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .box_index (rsp_chan.box_index),
   .keep      (rsp_chan.keep),
   .overflow  (rsp_chan.overflow),
   .set_done  (rsp_chan.set_done)
);

`default_nettype wire
